// File: src/timer_pool_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// Timer pool scheduler assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TIMER_POOL_SCHEDULER_UNIT_DEFINES_SVH
`define TIMER_POOL_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define TPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// Timer pool scheduler package
// Codes, state encoding and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int MS_W          = 10;
   localparam int PERIOD_W      = 16;
   localparam int TICK_W        = 32;
   localparam int DIV_CNT_W     = 5;

   localparam logic [MS_W-1:0] TICK_MS_RST = MS_W'(1);
   localparam logic CSR_IDX_TICK_MS = 1'b0;

   typedef enum logic [2:0] {
      FUNC_TICK    = 3'd0,
      FUNC_ALLOC   = 3'd1,
      FUNC_FREE    = 3'd2,
      FUNC_START   = 3'd3,
      FUNC_RESTART = 3'd4,
      FUNC_STOP    = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      KIND_STATUS    = 2'd0,
      KIND_EXPIRED   = 2'd1,
      KIND_TICK_DONE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NO_FREE = 2'd1,
      STS_TIMING  = 2'd2,
      STS_ZERO    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_SEL_ZERO = 2'd0,
      SLOT_SEL_REQ  = 2'd1,
      SLOT_SEL_SCAN = 2'd2
   } slot_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ALLOC,
      S_PREP,
      S_DIV,
      S_ARM,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_TICK_DONE
   } state_type;

   typedef struct packed {
      logic         load;
      logic         tick_inc;
      logic         scan_clr;
      logic         scan_inc;
      logic         alloc_wr;
      logic         free_slot;
      logic         stop_slot;
      logic         div_start;
      logic         div_step;
      logic         arm;
      logic         expire;
      logic         emit;
      kind_type     emit_kind;
      slot_sel_type emit_slot;
      status_type   emit_status;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     si_valid;
      logic     si_timing;
      logic     period_zero;
      logic     scan_free;
      logic     scan_last;
      logic     hit;
      logic     div_done;
   } sta_type;

endpackage

// File: src/tps_ctrl.sv
// ----------------------------------------------------------------------------
// Timer pool scheduler controller
// Sequences command decode, slot scans, the period divider and result words.
// ----------------------------------------------------------------------------
module tps_ctrl
   import tps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd,
   input  sta_type sta
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.emit_last = 1'b1;
            cmd.emit_slot = SLOT_SEL_REQ;
            state_in      = S_IDLE;
            unique case (sta.func)
               FUNC_TICK: begin
                  cmd.tick_inc = 1'b1;
                  cmd.scan_clr = 1'b1;
                  state_in     = S_SCAN_RD;
               end
               FUNC_ALLOC: begin
                  if (sta.period_zero) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_slot   = SLOT_SEL_ZERO;
                     cmd.emit_status = STS_ZERO;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = S_ALLOC;
                  end
               end
               FUNC_FREE: begin
                  cmd.free_slot = sta.si_valid;
                  cmd.emit      = 1'b1;
               end
               FUNC_START: begin
                  if (sta.si_valid && sta.si_timing) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = STS_TIMING;
                  end else if (sta.si_valid) begin
                     state_in = S_PREP;
                  end else begin
                     cmd.emit = 1'b1;
                  end
               end
               FUNC_RESTART: begin
                  if (sta.si_valid) begin
                     state_in = S_PREP;
                  end else begin
                     cmd.emit = 1'b1;
                  end
               end
               FUNC_STOP: begin
                  cmd.stop_slot = sta.si_valid;
                  cmd.emit      = 1'b1;
               end
               default: begin
                  cmd.emit      = 1'b1;
                  cmd.emit_slot = SLOT_SEL_ZERO;
               end
            endcase
         end
         S_ALLOC: begin
            cmd.emit_last = 1'b1;
            if (sta.scan_free) begin
               cmd.alloc_wr  = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_slot = SLOT_SEL_SCAN;
               state_in      = S_IDLE;
            end else if (sta.scan_last) begin
               cmd.emit        = 1'b1;
               cmd.emit_slot   = SLOT_SEL_ZERO;
               cmd.emit_status = STS_NO_FREE;
               state_in        = S_IDLE;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_PREP: begin
            // period read issued during dispatch is available here
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sta.div_done) begin
               state_in = S_ARM;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_ARM: begin
            cmd.arm       = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_slot = SLOT_SEL_REQ;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (sta.hit) begin
               cmd.expire    = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_EXPIRED;
               cmd.emit_slot = SLOT_SEL_SCAN;
            end
            if (sta.scan_last) begin
               state_in = S_TICK_DONE;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_TICK_DONE: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_TICK_DONE;
            cmd.emit_slot = SLOT_SEL_ZERO;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: src/tps_dp.sv
// ----------------------------------------------------------------------------
// Timer pool scheduler datapath
// Slot flags, period and deadline memories, tick counter, divider, result word.
// ----------------------------------------------------------------------------
module tps_dp
   import tps_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sta_type             sta,
   input  logic [2:0]          req_func,
   input  logic [3:0]          req_slot_index,
   input  logic [PERIOD_W-1:0] req_period_ms,
   input  logic [MS_W-1:0]     tick_ms,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_result_kind,
   output logic [3:0]          rsp_slot,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   // latched command word
   logic [2:0]          func_ff;
   logic [3:0]          si_ff;
   logic [PERIOD_W-1:0] period_ff;

   logic [TICK_W-1:0]    tick_ff;
   logic [NUM_SLOTS-1:0] busy_ff, busy_in;
   logic [NUM_SLOTS-1:0] timing_ff, timing_in;
   logic [NUM_SLOTS-1:0] pv_ff, pv_in;   // period entry written since reset
   logic [SLOT_W-1:0]    scan_ff;

   logic [PERIOD_W-1:0] period_mem [NUM_SLOTS];
   logic [TICK_W-1:0]   deadline_mem [NUM_SLOTS];
   logic [PERIOD_W-1:0] period_rd_ff;
   logic                pv_rd_ff;
   logic [TICK_W-1:0]   deadline_rd_ff;

   logic [MS_W-1:0]      div_rem_ff;
   logic [MS_W-1:0]      div_dsr_ff;
   logic [PERIOD_W-1:0]  div_quo_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [MS_W:0]        div_trial;
   logic                 div_ge;
   logic [MS_W:0]        div_diff;

   logic [SLOT_W+3:0] si_ext;
   logic [SLOT_W+3:0] scan_ext;
   logic [SLOT_W-1:0] si_idx;
   logic              si_valid;
   logic [TICK_W-1:0] ticks;

   logic       rsp_strobe_ff;
   logic [1:0] rsp_kind_ff;
   logic [3:0] rsp_slot_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_last_ff;
   logic [3:0] emit_slot;

   assign si_ext   = {{SLOT_W{1'b0}}, si_ff};
   assign si_idx   = si_ext[SLOT_W-1:0];
   assign scan_ext = {4'b0000, scan_ff};
   assign si_valid = 32'(si_ff) < 32'(NUM_SLOTS);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         si_ff     <= req_slot_index;
         period_ff <= req_period_ms;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      timing_in = timing_ff;
      pv_in     = pv_ff;
      if (cmd.alloc_wr) begin
         busy_in[scan_ff] = 1'b1;
         pv_in[scan_ff]   = 1'b1;
      end
      if (cmd.free_slot) begin
         busy_in[si_idx] = 1'b0;
      end
      if (cmd.arm) begin
         timing_in[si_idx] = 1'b1;
      end
      if (cmd.stop_slot) begin
         timing_in[si_idx] = 1'b0;
      end
      if (cmd.expire) begin
         timing_in[scan_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         busy_ff   <= '0;
         timing_ff <= '0;
         pv_ff     <= '0;
         scan_ff   <= '0;
      end else begin
         busy_ff   <= busy_in;
         timing_ff <= timing_in;
         pv_ff     <= pv_in;
         if (cmd.tick_inc) begin
            tick_ff <= tick_ff + TICK_W'(1);
         end
         if (cmd.scan_clr) begin
            scan_ff <= '0;
         end else if (cmd.scan_inc) begin
            scan_ff <= scan_ff + SLOT_W'(1);
         end
      end
   end

   // divider result of zero still arms for one tick
   assign ticks = (div_quo_ff == '0) ? TICK_W'(1)
                                     : {{(TICK_W-PERIOD_W){1'b0}}, div_quo_ff};

   always_ff @(posedge clock) begin
      if (cmd.alloc_wr) begin
         period_mem[scan_ff] <= period_ff;
      end
      period_rd_ff <= period_mem[si_idx];
      pv_rd_ff     <= pv_ff[si_idx];
      if (cmd.arm) begin
         deadline_mem[si_idx] <= tick_ff + ticks;
      end
      deadline_rd_ff <= deadline_mem[scan_ff];
   end

   // restoring divider, one quotient bit per cycle
   assign div_trial = {div_rem_ff, div_quo_ff[PERIOD_W-1]};
   assign div_ge    = div_trial >= {1'b0, div_dsr_ff};
   assign div_diff  = div_trial - {1'b0, div_dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_rem_ff <= '0;
         div_dsr_ff <= (tick_ms == '0) ? MS_W'(1) : tick_ms;
         div_quo_ff <= pv_rd_ff ? period_rd_ff : '0;
      end else if (cmd.div_step) begin
         div_rem_ff <= div_ge ? div_diff[MS_W-1:0] : div_trial[MS_W-1:0];
         div_quo_ff <= {div_quo_ff[PERIOD_W-2:0], div_ge};
      end
   end

   always_comb begin
      sta             = '0;
      sta.func        = func_type'(func_ff);
      sta.si_valid    = si_valid;
      sta.si_timing   = timing_ff[si_idx];
      sta.period_zero = (period_ff == '0);
      sta.scan_free   = !busy_ff[scan_ff];
      sta.scan_last   = (scan_ff == SLOT_W'(NUM_SLOTS - 1));
      sta.hit         = busy_ff[scan_ff] && timing_ff[scan_ff] && (deadline_rd_ff == tick_ff);
      sta.div_done    = (div_cnt_ff == DIV_CNT_W'(PERIOD_W));
   end

   always_comb begin
      unique case (cmd.emit_slot)
         SLOT_SEL_REQ:  emit_slot = si_ff;
         SLOT_SEL_SCAN: emit_slot = scan_ext[3:0];
         default:       emit_slot = 4'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.emit_kind;
         rsp_slot_ff   <= emit_slot;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: src/timer_pool_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Timer pool scheduler unit
// Pool of one-shot timers with a tick counter and an APB-style config port.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the command's last result word has been produced. Each result word is
// shown for one cycle with rsp_strobe and cannot be held off by the receiver,
// so it must be captured on that cycle. Words appear in the cycle after the
// internal step that makes them. Free, stop and rejected commands finish in
// the decode state; allocate decodes, then scans the slot flags at one slot a
// cycle for the first free slot; start and restart that arm a slot pass
// through the 16-step serial divider that turns the period into ticks; a tick
// reads, then compares, the deadline of each slot in turn and emits one word
// per expired slot in slot order followed by a tick-done word.
module timer_pool_scheduler_unit
   import tps_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_func,
   input  logic [3:0]          req_slot_index,
   input  logic [PERIOD_W-1:0] req_period_ms,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_result_kind,
   output logic [3:0]          rsp_slot,
   output logic [1:0]          rsp_status,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cmd_type cmd;
   sta_type sta;

   logic [MS_W-1:0] tick_ms_ff, tick_ms_in;
   logic            csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == CSR_IDX_TICK_MS);

   assign tick_ms_in = csr_wr ? pwdata[MS_W-1:0] : tick_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff <= TICK_MS_RST;
      end else begin
         tick_ms_ff <= tick_ms_in;
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_TICK_MS) ? {{(32-MS_W){1'b0}}, tick_ms_ff}
                                                 : 32'd0;

   tps_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sta   (sta)
   );

   tps_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sta             (sta),
      .req_func        (req_func),
      .req_slot_index  (req_slot_index),
      .req_period_ms   (req_period_ms),
      .tick_ms         (tick_ms_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot        (rsp_slot),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

// File: src/tps_checker.sv
// ----------------------------------------------------------------------------
// Timer pool scheduler checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
`include "timer_pool_scheduler_unit_defines.svh"

module tps_checker
   import tps_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [1:0] rsp_result_kind,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   `TPS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "busy not raised after accept")

   `TPS_ASSERT_SAME(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy,
      "busy held past last word")

   `TPS_ASSERT_SAME(a_mid_expired, clock, reset, rsp_strobe && !rsp_last,
      rsp_result_kind == KIND_EXPIRED, "non-final word is not an expiry")

   `TPS_ASSERT_SAME(a_idle_word, clock, reset, rsp_strobe && !busy, rsp_last,
      "idle word without last")

   `TPS_ASSERT_SAME(a_status_ok, clock, reset, rsp_strobe && rsp_result_kind != KIND_STATUS,
      rsp_status == STS_OK, "expiry or tick-done word carries status")

endmodule

bind timer_pool_scheduler_unit tps_checker u_tps_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_result_kind (rsp_result_kind),
   .rsp_status      (rsp_status),
   .rsp_last        (rsp_last)
);
